// ----- sv/nwk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nwk_pkg
// Shared types and constants of the number-to-word-keys unit.
// ----------------------------------------------------------------------------
package nwk_pkg;

   // input and result widths
   localparam int VALUE_W  = 32;
   localparam int KEY_W    = 30;

   // decimal digits of one input value
   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = 10;
   localparam int DIGITS_W   = DIGIT_W * NUM_DIGITS;
   localparam int CNT_W      = $clog2(NUM_DIGITS);

   // divide by ten: q = (v * RECIP) >> RECIP_SHIFT, exact for 32-bit v
   localparam logic [VALUE_W-1:0] RECIP       = 32'hCCCC_CCCD;
   localparam int                 RECIP_SHIFT = 35;
   localparam int                 QUOT_W      = 2 * VALUE_W - RECIP_SHIFT;

   // word keys
   localparam logic [KEY_W-1:0] KEY_ZERO     = 30'd0;
   localparam logic [KEY_W-1:0] KEY_TEN      = 30'd10;
   localparam logic [KEY_W-1:0] KEY_HUNDRED  = 30'd100;
   localparam logic [KEY_W-1:0] KEY_THOUSAND = 30'd1000;
   localparam logic [KEY_W-1:0] KEY_MILLION  = 30'd1000000;
   localparam logic [KEY_W-1:0] KEY_BILLION  = 30'd1000000000;

   // five word places per group of three digits, four groups, plus the zero word
   localparam int NUM_GROUPS     = 4;
   localparam int SLOTS_PER_GRP  = 5;
   localparam int SLOT_HUND_DIG  = 0;
   localparam int SLOT_HUNDRED   = 1;
   localparam int SLOT_TENS      = 2;
   localparam int SLOT_ONES      = 3;
   localparam int SLOT_SCALE     = 4;
   localparam int SLOT_ZERO      = NUM_GROUPS * SLOTS_PER_GRP;
   localparam int NUM_SLOTS      = SLOT_ZERO + 1;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef logic [DIGITS_W-1:0] digits_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_CONVERT,
      FRONT_HOLD
   } front_state_type;

   // queue status seen by both neighbors
   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage : nwk_pkg
`default_nettype wire

// ----- sv/nwk_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nwk_front
// Accepts an item and splits its value into ten decimal digits, one digit
// per cycle, then pushes the digit set into the queue.
// ----------------------------------------------------------------------------
module nwk_front (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_push,
   input  wire [nwk_pkg::VALUE_W-1:0]    req_value,
   output logic                          req_full,
   input  nwk_pkg::queue_status_type     q_status,
   output logic                          q_push,
   output nwk_pkg::digits_type           q_data
);
   import nwk_pkg::*;

   front_state_type          state_ff, state_in;
   logic [VALUE_W-1:0]       val_ff, val_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   digits_type               digits_ff, digits_in;
   logic                     accept;
   logic [2*VALUE_W-1:0]     product;
   logic [QUOT_W-1:0]        quot;
   logic [VALUE_W-1:0]       quot_x10;
   logic [VALUE_W-1:0]       rem;

   // divide by ten through the reciprocal, remainder by shift-add
   always_comb begin
      product  = val_ff * RECIP;
      quot     = product[2*VALUE_W-1:RECIP_SHIFT];
      quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
      rem      = val_ff - quot_x10;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FRONT_IDLE: begin
            if (accept) state_in = FRONT_CONVERT;
         end
         FRONT_CONVERT: begin
            if (cnt_ff == CNT_W'(NUM_DIGITS - 1)) state_in = FRONT_HOLD;
         end
         FRONT_HOLD: begin
            if (!q_status.full) state_in = accept ? FRONT_CONVERT : FRONT_IDLE;
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_full = 1'b1;
      q_push   = 1'b0;
      case (state_ff)
         FRONT_IDLE: begin
            req_full = 1'b0;
         end
         FRONT_CONVERT: begin
            req_full = 1'b1;
         end
         FRONT_HOLD: begin
            req_full = q_status.full;
            q_push   = !q_status.full;
         end
         default: begin
            req_full = 1'b1;
         end
      endcase
   end

   assign accept = req_push && !req_full;
   assign q_data = digits_ff;

   // load a new value, or peel off one digit per cycle
   always_comb begin
      val_in    = val_ff;
      cnt_in    = cnt_ff;
      digits_in = digits_ff;
      if (accept) begin
         val_in = req_value;
         cnt_in = '0;
      end else if (state_ff == FRONT_CONVERT) begin
         val_in    = VALUE_W'(quot);
         cnt_in    = cnt_ff + 1'b1;
         digits_in = {rem[DIGIT_W-1:0], digits_ff[DIGITS_W-1:DIGIT_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff    <= val_in;
      cnt_ff    <= cnt_in;
      digits_ff <= digits_in;
   end

endmodule : nwk_front
`default_nettype wire

// ----- sv/nwk_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nwk_queue
// Short queue of digit sets between the front and the back.
// ----------------------------------------------------------------------------
module nwk_queue #(
   parameter int DEPTH = nwk_pkg::QUEUE_DEPTH
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  nwk_pkg::digits_type        push_data,
   input  wire                        pop,
   output nwk_pkg::digits_type        head_data,
   output nwk_pkg::queue_status_type  status
);
   import nwk_pkg::*;

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   digits_type          mem [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                do_push, do_pop;

   assign status.full  = (count_ff == COUNT_W'(DEPTH));
   assign status.valid = (count_ff != '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;
   assign head_data    = mem[rd_ptr_ff];

   // advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule : nwk_queue
`default_nettype wire

// ----- sv/nwk_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nwk_back
// Turns one digit set into its word keys: builds a mask of the word places
// that speak, then emits the lowest remaining place each cycle unless the output is held.
// ----------------------------------------------------------------------------
module nwk_back (
   input  wire                         clock,
   input  wire                         reset,
   input  nwk_pkg::queue_status_type   q_status,
   input  nwk_pkg::digits_type         q_data,
   output logic                        q_pop,
   input  wire                         rsp_pop,
   output logic                        rsp_empty,
   output logic [nwk_pkg::KEY_W-1:0]   rsp_word_key,
   output logic                        rsp_last_word
);
   import nwk_pkg::*;

   logic                     busy_ff, busy_in;
   logic [NUM_SLOTS-1:0]     mask_ff, mask_in;
   digits_type               digits_ff, digits_in;
   logic                     out_valid_ff, out_valid_in;
   logic [KEY_W-1:0]         out_key_ff, out_key_in;
   logic                     out_last_ff, out_last_in;

   logic [KEY_W-1:0]         slot_key [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]     new_mask;
   logic [NUM_SLOTS-1:0]     lowest;
   logic [NUM_SLOTS-1:0]     rest;
   logic [KEY_W-1:0]         sel_key;
   logic                     advance, last, load;

   // digits of group g (0 = billions) are h, t, o; scale keys per group
   function automatic logic [DIGIT_W-1:0] dig(input digits_type d, input int idx);
      return d[idx*DIGIT_W +: DIGIT_W];
   endfunction

   function automatic logic [KEY_W-1:0] scale_of(input int g);
      logic [KEY_W-1:0] s;
      case (g)
         0:       s = KEY_BILLION;
         1:       s = KEY_MILLION;
         2:       s = KEY_THOUSAND;
         default: s = KEY_ZERO;
      endcase
      return s;
   endfunction

   // mask of word places for a fresh digit set
   always_comb begin
      logic [DIGIT_W-1:0] h, t, o;
      new_mask = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         if (g == 0) begin
            h = '0;
            t = '0;
            o = dig(q_data, NUM_DIGITS - 1);
         end else begin
            h = dig(q_data, 3 * (NUM_GROUPS - 1 - g) + 2);
            t = dig(q_data, 3 * (NUM_GROUPS - 1 - g) + 1);
            o = dig(q_data, 3 * (NUM_GROUPS - 1 - g));
         end
         new_mask[g*SLOTS_PER_GRP + SLOT_HUND_DIG] = (h != '0);
         new_mask[g*SLOTS_PER_GRP + SLOT_HUNDRED]  = (h != '0);
         new_mask[g*SLOTS_PER_GRP + SLOT_TENS]     = (t != '0);
         new_mask[g*SLOTS_PER_GRP + SLOT_ONES]     = (o != '0) && (t != DIGIT_W'(1));
         new_mask[g*SLOTS_PER_GRP + SLOT_SCALE]    =
            (g != NUM_GROUPS - 1) && ((h | t | o) != '0);
      end
      new_mask[SLOT_ZERO] = (q_data == '0);
   end

   // key of every word place for the digit set at work
   always_comb begin
      logic [DIGIT_W-1:0] h, t, o;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         if (g == 0) begin
            h = '0;
            t = '0;
            o = dig(digits_ff, NUM_DIGITS - 1);
         end else begin
            h = dig(digits_ff, 3 * (NUM_GROUPS - 1 - g) + 2);
            t = dig(digits_ff, 3 * (NUM_GROUPS - 1 - g) + 1);
            o = dig(digits_ff, 3 * (NUM_GROUPS - 1 - g));
         end
         slot_key[g*SLOTS_PER_GRP + SLOT_HUND_DIG] = KEY_W'(h);
         slot_key[g*SLOTS_PER_GRP + SLOT_HUNDRED]  = KEY_HUNDRED;
         slot_key[g*SLOTS_PER_GRP + SLOT_TENS]     = (t == DIGIT_W'(1)) ?
            KEY_TEN + KEY_W'(o) : KEY_W'({t, 3'b000}) + KEY_W'({t, 1'b0});
         slot_key[g*SLOTS_PER_GRP + SLOT_ONES]     = KEY_W'(o);
         slot_key[g*SLOTS_PER_GRP + SLOT_SCALE]    = scale_of(g);
      end
      slot_key[SLOT_ZERO] = KEY_ZERO;
   end

   // pick the earliest remaining place
   always_comb begin
      lowest  = mask_ff & (~mask_ff + 1'b1);
      rest    = mask_ff & ~lowest;
      sel_key = '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         sel_key = sel_key | (lowest[s] ? slot_key[s] : '0);
      end
   end

   assign advance = busy_ff && (!out_valid_ff || rsp_pop);
   assign last    = (rest == '0);
   assign load    = q_status.valid && (!busy_ff || (advance && last));
   assign q_pop   = load;

   // sequence control and output register
   always_comb begin
      busy_in      = busy_ff;
      mask_in      = mask_ff;
      digits_in    = digits_ff;
      out_valid_in = out_valid_ff;
      out_key_in   = out_key_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         mask_in = rest;
         if (last) busy_in = 1'b0;
         out_valid_in = 1'b1;
         out_key_in   = sel_key;
         out_last_in  = last;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         busy_in   = 1'b1;
         mask_in   = new_mask;
         digits_in = q_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      digits_ff   <= digits_in;
      out_key_ff  <= out_key_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_word_key  = out_key_ff;
   assign rsp_last_word = out_last_ff;

endmodule : nwk_back
`default_nettype wire

// ----- sv/number_to_word_keys_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// number_to_word_keys_unit
// Spells an unsigned 32-bit number as a sequence of English word keys.
//
// Input item: req_value, accepted at a clock edge with req_push high and
// req_full low. Result items: rsp_word_key and rsp_last_word, shown while
// rsp_empty is low and taken at an edge with rsp_pop high. Each item gives
// 1 to 16 keys in reading order; the final one has rsp_last_word set.
// The front splits the value into decimal digits with one divide-by-ten
// per cycle, then hands the digit set to the queue and can take the next
// item in that same cycle. The back emits one key per cycle from the
// output register unless a shown key is held there by rsp_pop low.
// A two-entry queue between front and back lets either side stall alone;
// a held rsp_pop low stops key emission, then fills the queue, then raises
// req_full. Reset empties the queue and the output register; no state
// outlives an item.
// ----------------------------------------------------------------------------
module number_to_word_keys_unit #(
   parameter int QUEUE_DEPTH = nwk_pkg::QUEUE_DEPTH
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_push,
   input  wire [nwk_pkg::VALUE_W-1:0]  req_value,
   output logic                        req_full,
   input  wire                         rsp_pop,
   output logic                        rsp_empty,
   output logic [nwk_pkg::KEY_W-1:0]   rsp_word_key,
   output logic                        rsp_last_word
);
   import nwk_pkg::*;

   queue_status_type  q_status;
   logic              q_push;
   logic              q_pop;
   digits_type        q_in_data;
   digits_type        q_head_data;

   // digit extraction
   nwk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_value (req_value),
      .req_full  (req_full),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_data    (q_in_data)
   );

   // decoupling queue
   nwk_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .head_data (q_head_data),
      .status    (q_status)
   );

   // key sequencing
   nwk_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_data        (q_head_data),
      .q_pop         (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_word_key  (rsp_word_key),
      .rsp_last_word (rsp_last_word)
   );

endmodule : number_to_word_keys_unit
`default_nettype wire
